// ===== src/pmt_pkg.sv =====
// ----------------------------------------------------------------------------
// Peer membership table package
// Table sizing, command and status codes, the entry layout and the control
// and status structures that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package pmt_pkg;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned ID_W     = 64;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned PORT_W   = 16;
  localparam int unsigned SLOT_W   = 8;
  localparam int unsigned COUNT_W  = 9;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD     = 3'd0,
    CMD_REMOVE  = 3'd1,
    CMD_UPDATE  = 3'd2,
    CMD_PROMOTE = 3'd3,
    CMD_LOOKUP  = 3'd4,
    CMD_READ    = 3'd5,
    CMD_ALLOC   = 3'd6
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_EXISTS   = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_INVALID  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_MOVE,
    S_FETCH,
    S_EXEC,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] port;
    logic              learner;
  } entry_t;

  typedef struct packed {
    status_e            status;
    logic [ID_W-1:0]    id;
    logic [ADDR_W-1:0]  addr;
    logic [PORT_W-1:0]  port;
    logic               learner;
    logic [COUNT_W-1:0] count;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic scan_rd;
    logic move_rd;
    logic fetch_rd;
    logic exec;
    logic load_out;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_e cmd;
    logic ptr_end;
    logic hit;
    logic rd_pending;
    logic out_busy;
  } dp_status_t;

endpackage

// ===== src/pmt_req_if.sv =====
// ----------------------------------------------------------------------------
// Peer membership table request channel
// Valid/ready channel that carries one command beat to the table.
// ----------------------------------------------------------------------------
interface pmt_req_if;

  logic                         valid;
  logic                         ready;
  logic [pmt_pkg::CMD_W-1:0]    cmd;
  logic [pmt_pkg::ID_W-1:0]     match_id;
  logic [pmt_pkg::ID_W-1:0]     entry_id;
  logic [pmt_pkg::ADDR_W-1:0]   entry_addr;
  logic [pmt_pkg::PORT_W-1:0]   entry_port;
  logic                         entry_learner;
  logic [pmt_pkg::SLOT_W-1:0]   slot_index;

  modport source (
    output valid, cmd, match_id, entry_id, entry_addr, entry_port, entry_learner,
           slot_index,
    input  ready
  );

  modport sink (
    input  valid, cmd, match_id, entry_id, entry_addr, entry_port, entry_learner,
           slot_index,
    output ready
  );

endinterface

// ===== src/pmt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Peer membership table response channel
// Valid/ready channel that carries one result beat from the table.
// ----------------------------------------------------------------------------
interface pmt_rsp_if;

  logic                          valid;
  logic                          ready;
  logic [pmt_pkg::STATUS_W-1:0]  status;
  logic [pmt_pkg::ID_W-1:0]      out_id;
  logic [pmt_pkg::ADDR_W-1:0]    out_addr;
  logic [pmt_pkg::PORT_W-1:0]    out_port;
  logic                          out_learner;
  logic [pmt_pkg::COUNT_W-1:0]   entry_count;

  modport source (
    output valid, status, out_id, out_addr, out_port, out_learner, entry_count,
    input  ready
  );

  modport sink (
    input  valid, status, out_id, out_addr, out_port, out_learner, entry_count,
    output ready
  );

endinterface

// ===== src/pmt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Peer membership table controller
// Sequences capture, the linear table walk, the extra read of a remove or a
// read by index, the final update step and the hand-off to the result register.
// ----------------------------------------------------------------------------
module pmt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pmt_pkg::dp_status_t st_i,
  output pmt_pkg::ctrl_cmd_t  cmd_o
);

  pmt_pkg::state_e state_q, state_d;
  logic            scan_end;

  // The walk ends on a hit or at the count, once the last read has landed.
  assign scan_end = (st_i.ptr_end || st_i.hit) && !st_i.rd_pending;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pmt_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pmt_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = pmt_pkg::S_DISPATCH;
        end
      end
      pmt_pkg::S_DISPATCH: begin
        unique case (st_i.cmd)
          pmt_pkg::CMD_READ: state_d = pmt_pkg::S_FETCH;
          pmt_pkg::CMD_ADD, pmt_pkg::CMD_REMOVE, pmt_pkg::CMD_UPDATE,
          pmt_pkg::CMD_PROMOTE, pmt_pkg::CMD_LOOKUP,
          pmt_pkg::CMD_ALLOC: state_d = pmt_pkg::S_SCAN;
          default: state_d = pmt_pkg::S_EXEC;
        endcase
      end
      pmt_pkg::S_SCAN: begin
        if (scan_end) begin
          if (st_i.cmd == pmt_pkg::CMD_REMOVE && st_i.hit) begin
            state_d = pmt_pkg::S_MOVE;
          end else begin
            state_d = pmt_pkg::S_EXEC;
          end
        end
      end
      pmt_pkg::S_MOVE:  state_d = pmt_pkg::S_EXEC;
      pmt_pkg::S_FETCH: state_d = pmt_pkg::S_EXEC;
      pmt_pkg::S_EXEC:  state_d = pmt_pkg::S_DONE;
      pmt_pkg::S_DONE: begin
        if (!st_i.out_busy) begin
          state_d = pmt_pkg::S_IDLE;
        end
      end
      default: state_d = pmt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == pmt_pkg::S_IDLE);
    cmd_o          = '0;
    cmd_o.capture  = in_ready_o && in_valid_i;
    cmd_o.scan_rd  = (state_q == pmt_pkg::S_SCAN) && !st_i.ptr_end && !st_i.hit;
    cmd_o.move_rd  = (state_q == pmt_pkg::S_MOVE);
    cmd_o.fetch_rd = (state_q == pmt_pkg::S_FETCH);
    cmd_o.exec     = (state_q == pmt_pkg::S_EXEC);
    cmd_o.load_out = (state_q == pmt_pkg::S_DONE) && !st_i.out_busy;
  end

endmodule

// ===== src/pmt_dp.sv =====
// ----------------------------------------------------------------------------
// Peer membership table datapath
// Entry memory, command registers, the walk pointer with id compare and
// running maximum, the final update step and the result registers.
// ----------------------------------------------------------------------------
module pmt_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pmt_pkg::ID_W-1:0]         cfg_wdata_i,
  pmt_req_if.sink                          req,
  pmt_rsp_if.source                        rsp,
  input  pmt_pkg::ctrl_cmd_t               cmd_i,
  output pmt_pkg::dp_status_t              st_o
);

  localparam int unsigned IDX_W = pmt_pkg::IDX_W;
  localparam int unsigned CNT_W = pmt_pkg::CNT_W;

  pmt_pkg::entry_t mem [pmt_pkg::TABLE_DEPTH];

  pmt_pkg::cmd_e               cmd_q;
  logic [pmt_pkg::ID_W-1:0]    key_q;
  pmt_pkg::entry_t             ent_q;
  logic [pmt_pkg::SLOT_W-1:0]  slot_q;
  logic [pmt_pkg::ID_W-1:0]    self_id_q;
  logic [CNT_W-1:0]            count_q, count_d;
  logic [CNT_W-1:0]            ptr_q;
  logic                        rd_scan_q;
  logic [IDX_W-1:0]            rd_idx_q;
  pmt_pkg::entry_t             rd_data_q;
  logic                        hit_q;
  logic [IDX_W-1:0]            pos_q;
  pmt_pkg::entry_t             hit_data_q;
  logic [pmt_pkg::ID_W-1:0]    max_q;
  pmt_pkg::result_t            res_q, res_d;
  pmt_pkg::result_t            out_q;
  logic                        out_valid_q;

  logic                        rd_en;
  logic [IDX_W-1:0]            rd_addr;
  logic [CNT_W-1:0]            last_w;
  logic                        cmp_hit;
  logic                        wr_en;
  logic [IDX_W-1:0]            wr_addr;
  pmt_pkg::entry_t             wr_data;
  pmt_pkg::entry_t             promoted;

  assign last_w = count_q - CNT_W'(1);

  // Read address select; the controller raises at most one read per cycle.
  always_comb begin
    rd_en   = cmd_i.scan_rd || cmd_i.move_rd || cmd_i.fetch_rd;
    rd_addr = ptr_q[IDX_W-1:0];
    if (cmd_i.move_rd) begin
      rd_addr = last_w[IDX_W-1:0];
    end else if (cmd_i.fetch_rd) begin
      rd_addr = slot_q[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
    if (cmd_i.exec && wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign cmp_hit = rd_scan_q && !hit_q && (cmd_q != pmt_pkg::CMD_ALLOC) &&
                   (rd_data_q.id == key_q);

  // Command capture and payload of the walk.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q         <= pmt_pkg::cmd_e'(req.cmd);
      key_q         <= (pmt_pkg::cmd_e'(req.cmd) == pmt_pkg::CMD_ADD) ?
                       req.entry_id : req.match_id;
      ent_q.id      <= req.entry_id;
      ent_q.addr    <= req.entry_addr;
      ent_q.port    <= req.entry_port;
      ent_q.learner <= req.entry_learner;
      slot_q        <= req.slot_index;
      max_q         <= self_id_q;
    end else if (rd_scan_q && rd_data_q.id > max_q) begin
      max_q <= rd_data_q.id;
    end
    if (rd_en) begin
      rd_idx_q <= rd_addr;
    end
    if (cmp_hit) begin
      pos_q      <= rd_idx_q;
      hit_data_q <= rd_data_q;
    end
    if (cmd_i.exec) begin
      res_q <= res_d;
    end
    if (cmd_i.load_out) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_id_q   <= '0;
      count_q     <= '0;
      ptr_q       <= '0;
      rd_scan_q   <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        self_id_q <= cfg_wdata_i;
      end
      if (cmd_i.capture) begin
        ptr_q <= '0;
        hit_q <= 1'b0;
      end else begin
        if (cmd_i.scan_rd) begin
          ptr_q <= ptr_q + CNT_W'(1);
        end
        if (cmp_hit) begin
          hit_q <= 1'b1;
        end
      end
      rd_scan_q <= cmd_i.scan_rd;
      if (cmd_i.exec) begin
        count_q <= count_d;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    promoted         = hit_data_q;
    promoted.learner = 1'b0;
  end

  // Final step of each command: status, result fields and the table write.
  always_comb begin
    wr_en        = 1'b0;
    wr_addr      = pos_q;
    wr_data      = ent_q;
    count_d      = count_q;
    res_d        = '0;
    res_d.status = pmt_pkg::ST_OK;
    unique case (cmd_q)
      pmt_pkg::CMD_ADD: begin
        if (hit_q) begin
          res_d.status = pmt_pkg::ST_EXISTS;
        end else if (count_q == CNT_W'(pmt_pkg::TABLE_DEPTH)) begin
          res_d.status = pmt_pkg::ST_FULL;
        end else begin
          wr_en   = 1'b1;
          wr_addr = count_q[IDX_W-1:0];
          count_d = count_q + CNT_W'(1);
        end
      end
      pmt_pkg::CMD_REMOVE: begin
        if (!hit_q) begin
          res_d.status = pmt_pkg::ST_NOTFOUND;
        end else begin
          wr_en   = 1'b1;
          wr_data = rd_data_q;
          count_d = last_w;
        end
      end
      pmt_pkg::CMD_UPDATE: begin
        if (!hit_q) begin
          res_d.status = pmt_pkg::ST_NOTFOUND;
        end else begin
          wr_en = 1'b1;
        end
      end
      pmt_pkg::CMD_PROMOTE: begin
        if (key_q == '0) begin
          res_d.status = pmt_pkg::ST_INVALID;
        end else if (!hit_q) begin
          res_d.status = pmt_pkg::ST_NOTFOUND;
        end else if (!hit_data_q.learner) begin
          res_d.status = pmt_pkg::ST_INVALID;
        end else begin
          wr_en   = 1'b1;
          wr_data = promoted;
        end
      end
      pmt_pkg::CMD_LOOKUP: begin
        if (!hit_q) begin
          res_d.status = pmt_pkg::ST_NOTFOUND;
        end else begin
          res_d.id      = hit_data_q.id;
          res_d.addr    = hit_data_q.addr;
          res_d.port    = hit_data_q.port;
          res_d.learner = hit_data_q.learner;
        end
      end
      pmt_pkg::CMD_READ: begin
        if (pmt_pkg::COUNT_W'(slot_q) >= pmt_pkg::COUNT_W'(count_q)) begin
          res_d.status = pmt_pkg::ST_NOTFOUND;
        end else begin
          res_d.id      = rd_data_q.id;
          res_d.addr    = rd_data_q.addr;
          res_d.port    = rd_data_q.port;
          res_d.learner = rd_data_q.learner;
        end
      end
      pmt_pkg::CMD_ALLOC: begin
        res_d.id = max_q + pmt_pkg::ID_W'(1);
      end
      default: begin
        res_d.status = pmt_pkg::ST_INVALID;
      end
    endcase
    res_d.count = pmt_pkg::COUNT_W'(count_d);
  end

  assign st_o.cmd        = cmd_q;
  assign st_o.ptr_end    = (ptr_q >= count_q);
  assign st_o.hit        = hit_q;
  assign st_o.rd_pending = rd_scan_q;
  assign st_o.out_busy   = out_valid_q && !rsp.ready;

  assign rsp.valid       = out_valid_q;
  assign rsp.status      = out_q.status;
  assign rsp.out_id      = out_q.id;
  assign rsp.out_addr    = out_q.addr;
  assign rsp.out_port    = out_q.port;
  assign rsp.out_learner = out_q.learner;
  assign rsp.entry_count = out_q.count;

endmodule

// ===== src/peer_membership_table_top.sv =====
// ----------------------------------------------------------------------------
// Peer membership table
// Packed table of cluster peers with add, remove, update, promote, lookup,
// read by index and id allocation, one command beat in, one result beat out.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake        Contents
//   req_i    in         valid / ready    command, ids, entry fields, slot
//   rsp_o    out        valid / ready    status, entry read or id, count
//   cfg      in         cfg_we_i         self id (64 bits)
//
// One command is worked on at a time. The walk reads the entry memory through
// its single registered read port, one entry a cycle, and stops at the first
// matching id (allocation walks every entry). Read by index skips the walk.
// Remove adds a step that fetches the last entry that fills the hole.
// Reset clears the entry count, the self id and all control; the entry memory
// keeps its contents, since no entry beyond the count is ever returned.
// The result sits in an output register, so a new command is taken while the
// previous result waits; a finished command holds only if that register is
// still full and stalled.
// ----------------------------------------------------------------------------
module peer_membership_table_top (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  pmt_req_if.sink                  req_i,
  pmt_rsp_if.source                rsp_o,
  input  logic                     cfg_we_i,
  input  logic [pmt_pkg::ID_W-1:0] cfg_wdata_i
);

  pmt_pkg::ctrl_cmd_t  ctrl_cmd;
  pmt_pkg::dp_status_t dp_status;

  // The controller owns the input handshake; the datapath owns the output.
  pmt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .st_i       (dp_status),
    .cmd_o      (ctrl_cmd)
  );

  pmt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req         (req_i),
    .rsp         (rsp_o),
    .cmd_i       (ctrl_cmd),
    .st_o        (dp_status)
  );

  // The table can never report more entries than it holds.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.entry_count <= pmt_pkg::COUNT_W'(pmt_pkg::TABLE_DEPTH)))
    else $error("entry count above table depth");

  // Only one source drives the memory read address in a cycle.
  a_one_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctrl_cmd.scan_rd, ctrl_cmd.move_rd, ctrl_cmd.fetch_rd}))
    else $error("conflicting memory reads");

  // A result is never loaded over one that is still stalled.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd.load_out |-> !(rsp_o.valid && !rsp_o.ready))
    else $error("result register overwritten");

  // After a command is taken, no other is taken until it has finished.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("second command accepted while busy");

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// Peer membership table testbench
// Drives command beats into the table and predicts every reply from a
// shadow copy of the entries, the entry count and the self id. Replies are
// checked in order, field by field, with random idling on both channels and
// one long reply stall that backs the table up.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pmt_pkg::*;

  // The command code that the table does not know. It must come back invalid.
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 3'd7;
  localparam logic [ID_W-1:0]  ID_ONES     = {ID_W{1'b1}};

  // Run shape. The watchdog limit covers the long reply stall plus the worst
  // gap on each side and a full walk of the table, many times over.
  localparam int unsigned PHASES       = 10;
  localparam int unsigned PHASE_BEATS  = 188;
  localparam int unsigned HOLD_AT      = 600;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 40;

  // One command beat as the testbench sees it. The command is kept as a raw
  // code so that the unknown code can be carried too.
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ID_W-1:0]   match_id;
    logic [ID_W-1:0]   entry_id;
    logic [ADDR_W-1:0] entry_addr;
    logic [PORT_W-1:0] entry_port;
    logic              entry_learner;
    logic [SLOT_W-1:0] slot_index;
  } command_t;

  // The scoreboard keeps a shadow of the peer table. Each accepted command is
  // applied to the shadow at once, and the reply it must produce is queued.
  class membership_scoreboard;
    bit [ID_W-1:0]   peer_id[TABLE_DEPTH];
    bit [ADDR_W-1:0] peer_addr[TABLE_DEPTH];
    bit [PORT_W-1:0] peer_port[TABLE_DEPTH];
    bit              peer_learner[TABLE_DEPTH];
    int unsigned     fill;
    bit [ID_W-1:0]   self_id;
    result_t         replies_due[$];
    int unsigned     errors;
    int unsigned     accepted;
    int unsigned     checked;
    int unsigned     status_hits[8];
    int unsigned     id_wraps;

    task report(string what);
      errors++;
      if (errors <= 40) begin
        $display("[%0t] mismatch: %s", $realtime, what);
      end
    endtask

    // Lowest position that holds the id, or -1.
    function int find_peer(bit [ID_W-1:0] key);
      for (int i = 0; i < fill; i++) begin
        if (peer_id[i] == key) begin
          return i;
        end
      end
      return -1;
    endfunction

    function void put_peer(int p, command_t c);
      peer_id[p]      = c.entry_id;
      peer_addr[p]    = c.entry_addr;
      peer_port[p]    = c.entry_port;
      peer_learner[p] = c.entry_learner;
    endfunction

    function result_t apply_command(command_t c);
      result_t       r;
      int            pos;
      int            last;
      bit [ID_W-1:0] top;
      r = '0;
      r.status = ST_OK;
      case (c.cmd)
        CMD_ADD: begin
          // A duplicate id is reported even when the table is also full.
          if (find_peer(c.entry_id) >= 0) begin
            r.status = ST_EXISTS;
          end else if (fill >= TABLE_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            put_peer(fill, c);
            fill++;
          end
        end
        CMD_REMOVE: begin
          pos = find_peer(c.match_id);
          if (pos < 0) begin
            r.status = ST_NOTFOUND;
          end else begin
            // The last entry moves into the hole to keep the table packed.
            last = fill - 1;
            peer_id[pos]      = peer_id[last];
            peer_addr[pos]    = peer_addr[last];
            peer_port[pos]    = peer_port[last];
            peer_learner[pos] = peer_learner[last];
            fill = last;
          end
        end
        CMD_UPDATE: begin
          pos = find_peer(c.match_id);
          if (pos < 0) begin
            r.status = ST_NOTFOUND;
          end else begin
            put_peer(pos, c);
          end
        end
        CMD_PROMOTE: begin
          if (c.match_id == '0) begin
            r.status = ST_INVALID;
          end else begin
            pos = find_peer(c.match_id);
            if (pos < 0) begin
              r.status = ST_NOTFOUND;
            end else if (!peer_learner[pos]) begin
              r.status = ST_INVALID;
            end else begin
              peer_learner[pos] = 1'b0;
            end
          end
        end
        CMD_LOOKUP: begin
          pos = find_peer(c.match_id);
          if (pos < 0) begin
            r.status = ST_NOTFOUND;
          end else begin
            r.id      = peer_id[pos];
            r.addr    = peer_addr[pos];
            r.port    = peer_port[pos];
            r.learner = peer_learner[pos];
          end
        end
        CMD_READ: begin
          if (c.slot_index >= fill) begin
            r.status = ST_NOTFOUND;
          end else begin
            r.id      = peer_id[c.slot_index];
            r.addr    = peer_addr[c.slot_index];
            r.port    = peer_port[c.slot_index];
            r.learner = peer_learner[c.slot_index];
          end
        end
        CMD_ALLOC: begin
          top = self_id;
          for (int i = 0; i < fill; i++) begin
            if (peer_id[i] > top) begin
              top = peer_id[i];
            end
          end
          r.id = top + 1'b1;
          if (r.id == '0) begin
            id_wraps++;
          end
        end
        default: begin
          r.status = ST_INVALID;
        end
      endcase
      r.count = COUNT_W'(fill);
      return r;
    endfunction

    function void note_command(command_t c);
      result_t r;
      r = apply_command(c);
      status_hits[r.status]++;
      accepted++;
      replies_due.push_back(r);
    endfunction

    task check_reply(result_t seen);
      result_t want;
      if (replies_due.size() == 0) begin
        report($sformatf("reply beat with no command waiting, status %0d", seen.status));
        return;
      end
      want = replies_due.pop_front();
      checked++;
      if (seen.status !== want.status)
        report($sformatf("reply %0d status %0d, want %0d", checked, seen.status, want.status));
      if (seen.id !== want.id)
        report($sformatf("reply %0d id %h, want %h", checked, seen.id, want.id));
      if (seen.addr !== want.addr)
        report($sformatf("reply %0d addr %h, want %h", checked, seen.addr, want.addr));
      if (seen.port !== want.port)
        report($sformatf("reply %0d port %h, want %h", checked, seen.port, want.port));
      if (seen.learner !== want.learner)
        report($sformatf("reply %0d learner %b, want %b", checked, seen.learner,
                         want.learner));
      if (seen.count !== want.count)
        report($sformatf("reply %0d count %0d, want %0d", checked, seen.count, want.count));
    endtask

    task check_drained();
      if (replies_due.size() != 0) begin
        report($sformatf("%0d replies never arrived", replies_due.size()));
      end
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [ID_W-1:0]     cfg_wdata_i;
  pmt_req_if           req_if ();
  pmt_rsp_if           rsp_if ();
  membership_scoreboard sb = new;

  // Ids of the current phase. A small pool makes hits, duplicates and a full
  // table common; it always holds id zero and the all-ones id.
  logic [ID_W-1:0]     id_pool[24];
  int unsigned         settings_used;

  peer_membership_table_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic logic [ID_W-1:0] rand_id64();
    return {$urandom, $urandom};
  endfunction

  // Idle cycles before the next beat. One stretch in three of 48 beats runs
  // back to back, so both idle patterns and full-rate traffic are seen.
  function automatic int unsigned pick_gap(int unsigned beat);
    if ((beat / 48) % 3 == 1) begin
      return 0;
    end
    return $urandom_range(0, 15);
  endfunction

  function automatic command_t command(logic [CMD_W-1:0] op, logic [ID_W-1:0] key,
                                       logic [ID_W-1:0] eid, logic [ADDR_W-1:0] a,
                                       logic [PORT_W-1:0] p, logic l,
                                       logic [SLOT_W-1:0] s);
    command_t c;
    c.cmd           = op;
    c.match_id      = key;
    c.entry_id      = eid;
    c.entry_addr    = a;
    c.entry_port    = p;
    c.entry_learner = l;
    c.slot_index    = s;
    return c;
  endfunction

  function automatic void refresh_pool();
    id_pool[0] = '0;
    id_pool[1] = ID_ONES;
    for (int i = 2; i < 24; i++) begin
      // A few small ids so that a small self id can still win allocation.
      id_pool[i] = (i < 8) ? ID_W'($urandom_range(1, 40)) : rand_id64();
    end
  endfunction

  function automatic logic [ID_W-1:0] present_or_pool();
    if (sb.fill > 0 && $urandom_range(0, 99) < 70) begin
      return sb.peer_id[$urandom_range(0, sb.fill - 1)];
    end
    if ($urandom_range(0, 1) == 0) begin
      return id_pool[$urandom_range(0, 23)];
    end
    return rand_id64();
  endfunction

  // Random command. A growing stretch favors adds so the table fills up and
  // add meets a full table; a shrinking stretch favors removes and empties it.
  // A small share is pure noise over every field, the unknown code included.
  function automatic command_t make_random(bit grow);
    command_t    c;
    int unsigned roll;
    c.entry_addr    = $urandom;
    c.entry_port    = PORT_W'($urandom);
    c.entry_learner = 1'($urandom_range(0, 1));
    c.slot_index    = ($urandom_range(0, 4) == 0) ? SLOT_W'($urandom_range(0, 255))
                                                  : SLOT_W'($urandom_range(0, 17));
    if ($urandom_range(0, 99) < 8) begin
      c.cmd      = CMD_W'($urandom_range(0, 7));
      c.match_id = rand_id64();
      c.entry_id = rand_id64();
      return c;
    end
    c.match_id = present_or_pool();
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      c.entry_id = id_pool[$urandom_range(0, 23)];
    end else if (roll < 90) begin
      c.entry_id = rand_id64();
    end else begin
      c.entry_id = present_or_pool();
    end
    roll = $urandom_range(0, 99);
    if (grow) begin
      if      (roll < 45) c.cmd = CMD_ADD;
      else if (roll < 53) c.cmd = CMD_REMOVE;
      else if (roll < 63) c.cmd = CMD_UPDATE;
      else if (roll < 73) c.cmd = CMD_PROMOTE;
      else if (roll < 83) c.cmd = CMD_LOOKUP;
      else if (roll < 91) c.cmd = CMD_READ;
      else if (roll < 98) c.cmd = CMD_ALLOC;
      else                c.cmd = CMD_UNKNOWN;
    end else begin
      if      (roll < 12) c.cmd = CMD_ADD;
      else if (roll < 47) c.cmd = CMD_REMOVE;
      else if (roll < 57) c.cmd = CMD_UPDATE;
      else if (roll < 67) c.cmd = CMD_PROMOTE;
      else if (roll < 78) c.cmd = CMD_LOOKUP;
      else if (roll < 89) c.cmd = CMD_READ;
      else if (roll < 98) c.cmd = CMD_ALLOC;
      else                c.cmd = CMD_UNKNOWN;
    end
    return c;
  endfunction

  // Offers one command beat and returns once it is accepted. Valid stays high
  // into the next call, which either lowers it for a gap or puts the next
  // beat on the wires at the following falling edge.
  task automatic send_command(input command_t c);
    int unsigned gap;
    gap = pick_gap(sb.accepted);
    repeat (gap) begin
      @(negedge clk_i);
      req_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    req_if.cmd           <= c.cmd;
    req_if.match_id      <= c.match_id;
    req_if.entry_id      <= c.entry_id;
    req_if.entry_addr    <= c.entry_addr;
    req_if.entry_port    <= c.entry_port;
    req_if.entry_learner <= c.entry_learner;
    req_if.slot_index    <= c.slot_index;
    req_if.valid         <= 1'b1;
    do @(posedge clk_i); while (!(req_if.valid && req_if.ready));
    sb.note_command(c);
  endtask

  // The self id may only change while the table is idle: the request channel
  // is quiet and every reply has been taken. Since each command gives exactly
  // one reply, the table is idle once the last reply is in.
  task automatic write_self_id(input logic [ID_W-1:0] value);
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (sb.replies_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.self_id = value;
    settings_used++;
  endtask

  // Reply side. Ready is changed only at falling edges and the reply is
  // sampled at the rising edge. Once, the sink holds off for a long stretch
  // while commands keep coming, so the output register fills and the table
  // has to stall its request channel.
  initial begin : reply_sink
    int unsigned stall;
    int unsigned beats;
    bit          held;
    result_t     seen;
    stall = 0;
    beats = 0;
    held  = 1'b0;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        stall--;
      end else begin
        rsp_if.ready <= 1'b1;
      end
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) begin
        seen.status  = status_e'(rsp_if.status);
        seen.id      = rsp_if.out_id;
        seen.addr    = rsp_if.out_addr;
        seen.port    = rsp_if.out_port;
        seen.learner = rsp_if.out_learner;
        seen.count   = rsp_if.entry_count;
        sb.check_reply(seen);
        beats++;
        if (!held && beats == HOLD_AT) begin
          held  = 1'b1;
          stall = HOLD_CYCLES;
        end else begin
          stall = pick_gap(beats + 17);
        end
      end
    end
  end

  // Watchdog: any beat on either channel restarts the count.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Watchdog: no beat moved for %0d cycles, %0d replies outstanding.",
             quiet, sb.replies_due.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    logic [ID_W-1:0] half_a;
    logic [ID_W-1:0] half_5;
    logic [ID_W-1:0] setting;
    bit              grow;
    half_a = {(ID_W/4){4'hA}};
    half_5 = {(ID_W/4){4'h5}};
    settings_used = 0;

    // Every input is known from time zero.
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_wdata_i          = '0;
    req_if.valid         = 1'b0;
    req_if.cmd           = CMD_ADD;
    req_if.match_id      = '0;
    req_if.entry_id      = '0;
    req_if.entry_addr    = '0;
    req_if.entry_port    = '0;
    req_if.entry_learner = 1'b0;
    req_if.slot_index    = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, run with the largest self id so that allocation wraps.
    write_self_id(ID_ONES);
    // Empty table: allocation wraps to zero, every search misses.
    send_command(command(CMD_ALLOC,   '0, '0, '0, '0, 1'b0, '0));
    send_command(command(CMD_REMOVE,  64'd5, '0, '0, '0, 1'b0, '0));
    send_command(command(CMD_UPDATE,  64'd5, 64'd9, '1, '1, 1'b1, '0));
    send_command(command(CMD_LOOKUP,  ID_ONES, '0, '0, '0, 1'b0, '0));
    send_command(command(CMD_READ,    '0, '0, '0, '0, 1'b0, 8'd0));
    // Promoting id zero and the unknown code are both invalid.
    send_command(command(CMD_PROMOTE, '0, '0, '0, '0, 1'b0, '0));
    send_command(command(CMD_UNKNOWN, ID_ONES, ID_ONES, '1, '1, 1'b1, '1));
    // Entries at both extremes of every field, then a duplicate add.
    send_command(command(CMD_ADD,     '0, ID_ONES, '1, '1, 1'b1, '0));
    send_command(command(CMD_ADD,     ID_ONES, '0, '0, '0, 1'b0, '1));
    send_command(command(CMD_ADD,     '0, '0, '1, '1, 1'b1, '0));
    send_command(command(CMD_LOOKUP,  ID_ONES, '0, '0, '0, 1'b0, '0));
    // Promote a learner, then the same entry again now that it votes.
    send_command(command(CMD_PROMOTE, ID_ONES, '0, '0, '0, 1'b0, '0));
    send_command(command(CMD_PROMOTE, ID_ONES, '0, '0, '0, 1'b0, '0));
    send_command(command(CMD_PROMOTE, '0, '0, '0, '0, 1'b0, '0));
    // Update rewrites the id too.
    send_command(command(CMD_UPDATE,  '0, half_5, 32'h5555_5555, 16'h5555, 1'b1, '0));
    send_command(command(CMD_PROMOTE, half_5, '0, '0, '0, 1'b0, '0));
    // Reads inside, just past and far past the count.
    send_command(command(CMD_READ,    '0, '0, '0, '0, 1'b0, 8'd1));
    send_command(command(CMD_READ,    '0, '0, '0, '0, 1'b0, 8'd2));
    send_command(command(CMD_READ,    '0, '0, '0, '0, 1'b0, 8'd255));
    send_command(command(CMD_ALLOC,   '0, '0, '0, '0, 1'b0, '0));
    // Removing the first entry pulls the last one into its place.
    send_command(command(CMD_ADD,     '0, half_a, 32'hAAAA_AAAA, 16'hAAAA, 1'b0, '0));
    send_command(command(CMD_REMOVE,  ID_ONES, '0, '0, '0, 1'b0, '0));
    send_command(command(CMD_READ,    '0, '0, '0, '0, 1'b0, 8'd0));
    // Update with no duplicate check; the search must then take the lowest hit.
    send_command(command(CMD_UPDATE,  half_a, half_5, 32'h1, 16'h1, 1'b1, '0));
    send_command(command(CMD_LOOKUP,  half_5, '0, '0, '0, 1'b0, '0));

    // Random part, one self id setting per phase, the extremes among them.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 5)
        0:       setting = '0;
        1:       setting = ID_ONES;
        2:       setting = rand_id64();
        3:       setting = ID_W'($urandom_range(0, 40));
        default: setting = {1'b1, {(ID_W-1){1'b0}}};
      endcase
      write_self_id(setting);
      refresh_pool();
      for (int n = 0; n < PHASE_BEATS; n++) begin
        grow = (((n / 40) % 2) == 0) ^ ph[0];
        send_command(make_random(grow));
      end
    end

    // Drain: stop offering, wait for every reply, then let the table settle.
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (sb.replies_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    sb.check_drained();

    $display("Covered %0d command beats and %0d checked replies over %0d self id settings.",
             sb.accepted, sb.checked, settings_used);
    $display("Replies: ok %0d, exists %0d, full %0d, not found %0d, invalid %0d; %0d wraps.",
             sb.status_hits[ST_OK], sb.status_hits[ST_EXISTS], sb.status_hits[ST_FULL],
             sb.status_hits[ST_NOTFOUND], sb.status_hits[ST_INVALID], sb.id_wraps);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
